@@ rtl/core/pu_pkg.sv @@
// ----------------------------------------------------------------------------
// pu_pkg
// Shared types and constants for the particle update and shade pipeline.
// ----------------------------------------------------------------------------
package pu_pkg;

    localparam int LATENCY        = 11;
    localparam int KIN_STAGES     = 4;
    localparam int DIV_BITS       = 16;
    localparam int DIV_PER_STAGE  = 2;
    localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;

    localparam logic [15:0] TIME_STEP_RST  = 16'd1092;
    localparam logic [15:0] GRAVITY_RST    = 16'd30720;
    localparam logic [15:0] FRIC_HORIZ_RST = 16'd10240;
    localparam logic [15:0] FRIC_VERT_RST  = 16'd8192;
    localparam logic [15:0] SIZE_FLOOR_RST = 16'd128;

    localparam logic [2:0] CFG_TIME_STEP  = 3'd0;
    localparam logic [2:0] CFG_GRAVITY    = 3'd1;
    localparam logic [2:0] CFG_FRIC_HORIZ = 3'd2;
    localparam logic [2:0] CFG_FRIC_VERT  = 3'd3;
    localparam logic [2:0] CFG_SIZE_FLOOR = 3'd4;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic        [15:0] life_left;
        logic        [15:0] life_total;
        logic        [15:0] radius;
        logic        [15:0] shrink_rate;
        logic               falls;
        logic        [31:0] color_begin;
        logic        [31:0] color_final;
    } particle_in_t;

    typedef struct packed {
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] new_vel_x;
        logic signed [23:0] new_vel_y;
        logic        [15:0] new_life;
        logic        [15:0] new_radius;
        logic               alive;
        logic        [31:0] draw_color;
    } particle_out_t;

    typedef struct packed {
        logic [15:0] time_step;
        logic [15:0] gravity_accel;
        logic [15:0] friction_horizontal;
        logic [15:0] friction_vertical;
        logic [15:0] size_floor;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] new_pos_x;
        logic signed [23:0] new_pos_y;
        logic signed [23:0] new_vel_x;
        logic signed [23:0] new_vel_y;
        logic        [15:0] new_radius;
    } kin_t;

    typedef struct packed {
        logic [15:0] new_life;
        logic        alive;
        logic [31:0] draw_color;
    } shade_t;

endpackage

@@ rtl/core/pu_kin.sv @@
// ----------------------------------------------------------------------------
// pu_kin
// Kinematics pipeline: position, velocity with gravity and friction, size.
// ----------------------------------------------------------------------------
module pu_kin (
    input  logic                 aclk,
    input  logic                 en,
    input  pu_pkg::particle_in_t din,
    input  pu_pkg::cfg_t         cfg,
    output pu_pkg::kin_t         dout
);
    import pu_pkg::*;

    localparam int DELAY = LATENCY - KIN_STAGES;

    // stage 1
    logic signed [23:0] px1_reg, py1_reg, vx1_reg, vy1_reg;
    logic signed [40:0] mx1_reg, my1_reg;
    logic        [31:0] grav1_reg, lossx1_reg, lossy1_reg, shr1_reg;
    logic        [15:0] rad1_reg;
    logic               falls1_reg;
    // stage 2
    logic signed [23:0] npx2_reg, npy2_reg, vx2_reg;
    logic signed [24:0] vy2_reg;
    logic        [28:0] facx2_reg, facy2_reg;
    logic        [15:0] sz2_reg;
    // stage 3
    logic signed [23:0] npx3_reg, npy3_reg;
    logic signed [54:0] pvx3_reg, pvy3_reg;
    logic        [15:0] sz3_reg;
    // stage 4 and alignment
    kin_t               line_reg [DELAY+1];

    logic signed [41:0] sumx, sumy;
    logic signed [25:0] shx, shy;
    logic signed [24:0] vyw;
    logic signed [33:0] sdiff;
    logic signed [17:0] sz;
    logic signed [26:0] nvx, nvy;
    kin_t               k4;

    function automatic logic signed [23:0] sat26(input logic signed [25:0] x);
        logic signed [23:0] r;
        if (x > 26'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -26'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat27(input logic signed [26:0] x);
        logic signed [23:0] r;
        if (x > 27'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -27'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[23:0];
        end
        return r;
    endfunction

    function automatic logic [28:0] factor(input logic [31:0] loss);
        logic [28:0] r;
        if (loss >= 32'h1000_0000) begin
            r = '0;
        end else begin
            r = 29'h1000_0000 - loss[28:0];
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg    <= din.pos_x;
            py1_reg    <= din.pos_y;
            vx1_reg    <= din.vel_x;
            vy1_reg    <= din.vel_y;
            mx1_reg    <= din.vel_x * $signed({1'b0, cfg.time_step});
            my1_reg    <= din.vel_y * $signed({1'b0, cfg.time_step});
            grav1_reg  <= cfg.gravity_accel * cfg.time_step;
            lossx1_reg <= cfg.friction_horizontal * cfg.time_step;
            lossy1_reg <= cfg.friction_vertical * cfg.time_step;
            shr1_reg   <= din.shrink_rate * cfg.time_step;
            rad1_reg   <= din.radius;
            falls1_reg <= din.falls;
        end
    end

    always_comb begin
        sumx  = $signed({{2{px1_reg[23]}}, px1_reg, 16'b0}) + 42'(mx1_reg);
        sumy  = $signed({{2{py1_reg[23]}}, py1_reg, 16'b0}) + 42'(my1_reg);
        shx   = sumx[41:16];
        shy   = sumy[41:16];
        vyw   = 25'(vy1_reg);
        if (falls1_reg) begin
            vyw = 25'(vy1_reg) + $signed({9'b0, grav1_reg[31:16]});
        end
        sdiff = $signed({2'b0, rad1_reg, 16'b0}) - $signed({2'b0, shr1_reg});
        sz    = sdiff[33:16];
        if (sz < $signed({2'b0, cfg.size_floor})) begin
            sz = $signed({2'b0, cfg.size_floor});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            npx2_reg  <= sat26(shx);
            npy2_reg  <= sat26(shy);
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vyw;
            facx2_reg <= factor(lossx1_reg);
            facy2_reg <= factor(lossy1_reg);
            sz2_reg   <= sz[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            npx3_reg <= npx2_reg;
            npy3_reg <= npy2_reg;
            pvx3_reg <= 25'(vx2_reg) * $signed({1'b0, facx2_reg});
            pvy3_reg <= vy2_reg * $signed({1'b0, facy2_reg});
            sz3_reg  <= sz2_reg;
        end
    end

    always_comb begin
        nvx          = pvx3_reg[54:28];
        nvy          = pvy3_reg[54:28];
        k4.new_pos_x = npx3_reg;
        k4.new_pos_y = npy3_reg;
        k4.new_vel_x = sat27(nvx);
        k4.new_vel_y = sat27(nvy);
        k4.new_radius = sz3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= k4;
        end
    end

    for (genvar i = 0; i < DELAY; i++) begin : g_align
        always_ff @(posedge aclk) begin
            if (en) begin
                line_reg[i+1] <= line_reg[i];
            end
        end
    end

    assign dout = line_reg[DELAY];

endmodule

@@ rtl/core/pu_shade.sv @@
// ----------------------------------------------------------------------------
// pu_shade
// Life update, pipelined alpha divider, color blend and alpha fade.
// ----------------------------------------------------------------------------
module pu_shade (
    input  logic                 aclk,
    input  logic                 en,
    input  pu_pkg::particle_in_t din,
    input  logic [15:0]          time_step,
    output pu_pkg::shade_t       dout
);
    import pu_pkg::*;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] quo;
        logic [15:0] dvs;
        logic        sat;
        logic        alive;
        logic [15:0] life;
        logic [31:0] cb;
        logic [31:0] cf;
    } div_st_t;

    div_st_t     st_reg [DIV_STAGES+1];
    logic [7:0]  ch_reg [4];
    logic [16:0] alpha_reg;
    logic        alive_reg;
    logic [15:0] life_reg;
    shade_t      out_reg;

    logic signed [20:0] diff;
    logic signed [16:0] nl;
    div_st_t     st0;
    logic [16:0] alpha;
    logic [7:0]  ch [4];
    logic [24:0] afade;

    function automatic div_st_t div_step(input div_st_t s);
        div_st_t     r;
        logic [16:0] r2;
        r = s;
        for (int k = 0; k < DIV_PER_STAGE; k++) begin
            r2 = {r.rem, 1'b0};
            if (r2 >= {1'b0, r.dvs}) begin
                r2    = r2 - {1'b0, r.dvs};
                r.quo = {r.quo[14:0], 1'b1};
            end else begin
                r.quo = {r.quo[14:0], 1'b0};
            end
            r.rem = r2[15:0];
        end
        return r;
    endfunction

    always_comb begin
        diff      = $signed({1'b0, din.life_left, 4'b0}) - $signed({5'b0, time_step});
        nl        = diff[20:4];
        st0.rem   = nl[15:0];
        st0.quo   = '0;
        st0.dvs   = din.life_total;
        st0.alive = !nl[16] && (nl != '0);
        st0.life  = nl[15:0];
        st0.sat   = nl[15:0] >= din.life_total;
        st0.cb    = din.color_begin;
        st0.cf    = din.color_final;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0;
        end
    end

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i+1] <= div_step(st_reg[i]);
            end
        end
    end

    always_comb begin
        alpha = st_reg[DIV_STAGES].sat ? 17'h10000 : {1'b0, st_reg[DIV_STAGES].quo};
        for (int k = 0; k < 4; k++) begin
            logic signed [9:0]  dch;
            logic signed [28:0] prod;
            logic signed [28:0] acc;
            dch   = $signed({2'b0, st_reg[DIV_STAGES].cb[8*k +: 8]})
                  - $signed({2'b0, st_reg[DIV_STAGES].cf[8*k +: 8]});
            prod  = dch * $signed({1'b0, alpha});
            acc   = $signed({5'b0, st_reg[DIV_STAGES].cf[8*k +: 8], 16'b0}) + prod;
            ch[k] = acc[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                ch_reg[k] <= ch[k];
            end
            alpha_reg <= alpha;
            alive_reg <= st_reg[DIV_STAGES].alive;
            life_reg  <= st_reg[DIV_STAGES].life;
        end
    end

    assign afade = ch_reg[3] * alpha_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.alive      <= alive_reg;
            out_reg.new_life   <= alive_reg ? life_reg : 16'd0;
            out_reg.draw_color <= alive_reg ? {afade[23:16], ch_reg[2], ch_reg[1], ch_reg[0]}
                                            : 32'd0;
        end
    end

    assign dout = out_reg;

endmodule

@@ rtl/core/particle_update_and_shade_top.sv @@
// ----------------------------------------------------------------------------
// particle_update_and_shade_top
// Throughput: one particle per cycle; the whole pipeline holds while a
// result waits, and the alpha divider resolves two quotient bits per stage.
// Reset: synchronous active-low aresetn clears valid bits and restores
// the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module particle_update_and_shade_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pu_pkg::particle_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pu_pkg::particle_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import pu_pkg::*;

    cfg_t                 cfg_reg;
    logic [LATENCY-1:0]   valid_reg;
    logic                 en;
    kin_t                 kin;
    shade_t               shd;

    assign en        = m_ready || !valid_reg[LATENCY-1];
    assign s_ready   = en;
    assign m_valid   = valid_reg[LATENCY-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_step           <= TIME_STEP_RST;
            cfg_reg.gravity_accel       <= GRAVITY_RST;
            cfg_reg.friction_horizontal <= FRIC_HORIZ_RST;
            cfg_reg.friction_vertical   <= FRIC_VERT_RST;
            cfg_reg.size_floor          <= SIZE_FLOOR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TIME_STEP:  cfg_reg.time_step           <= cfg_data;
                CFG_GRAVITY:    cfg_reg.gravity_accel       <= cfg_data;
                CFG_FRIC_HORIZ: cfg_reg.friction_horizontal <= cfg_data;
                CFG_FRIC_VERT:  cfg_reg.friction_vertical   <= cfg_data;
                CFG_SIZE_FLOOR: cfg_reg.size_floor          <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LATENCY-2:0], s_valid};
        end
    end

    pu_kin u_kin (
        .aclk (aclk),
        .en   (en),
        .din  (s_data),
        .cfg  (cfg_reg),
        .dout (kin)
    );

    pu_shade u_shade (
        .aclk      (aclk),
        .en        (en),
        .din       (s_data),
        .time_step (cfg_reg.time_step),
        .dout      (shd)
    );

    always_comb begin
        m_data.new_pos_x  = kin.new_pos_x;
        m_data.new_pos_y  = kin.new_pos_y;
        m_data.new_vel_x  = kin.new_vel_x;
        m_data.new_vel_y  = kin.new_vel_y;
        m_data.new_life   = shd.new_life;
        m_data.new_radius = kin.new_radius;
        m_data.alive      = shd.alive;
        m_data.draw_color = shd.draw_color;
    end

endmodule
